/* src/smp_pkg.sv */
// Shared types for the symbolic mode parser: parse phase, operator codes,
// parser state and step result. No dependencies.
`default_nettype none
package smp_pkg;

   localparam int ModeWidth = 16;
   localparam int CharWidth = 8;

   typedef enum logic [3:0] {
      PH_START = 4'b0001,
      PH_OCT   = 4'b0010,
      PH_WHO   = 4'b0100,
      PH_PERM  = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_SET = 2'd2
   } op_type;

   typedef struct packed {
      logic [ModeWidth-1:0] work_mode;
      logic [ModeWidth-1:0] orig_mode;
      logic [ModeWidth-1:0] octal_acc;
      logic [2:0]           who_mask;
      op_type               op_kind;
      logic [2:0]           perm_bits;
      phase_type            phase;
      logic                 error_seen;
   } state_type;

   typedef struct packed {
      logic                 emit;
      logic [ModeWidth-1:0] mode;
      logic                 error;
   } result_type;

   localparam state_type StateReset = '{
      work_mode:  '0,
      orig_mode:  '0,
      octal_acc:  '0,
      who_mask:   '0,
      op_kind:    OP_ADD,
      perm_bits:  '0,
      phase:      PH_START,
      error_seen: 1'b0
   };

endpackage
`default_nettype wire

/* src/smp_step.sv */
// Next-state and result logic for one character beat of the mode parser.
// Depends on smp_pkg.
`default_nettype none
module smp_step (
   input  wire smp_pkg::state_type            state_cur,
   input  wire [smp_pkg::CharWidth-1:0]       symbol,
   input  wire                                first,
   input  wire [smp_pkg::ModeWidth-1:0]       start_mode,
   output smp_pkg::state_type                 state_nxt,
   output smp_pkg::result_type                result
);
   import smp_pkg::*;

   localparam logic [CharWidth-1:0] ChNul   = 8'h00;
   localparam logic [CharWidth-1:0] ChComma = 8'h2c;
   localparam logic [CharWidth-1:0] ChZero  = 8'h30;
   localparam logic [CharWidth-1:0] ChSeven = 8'h37;
   localparam logic [CharWidth-1:0] ChPlus  = 8'h2b;
   localparam logic [CharWidth-1:0] ChMinus = 8'h2d;
   localparam logic [CharWidth-1:0] ChEq    = 8'h3d;
   localparam logic [CharWidth-1:0] ChU     = 8'h75;
   localparam logic [CharWidth-1:0] ChG     = 8'h67;
   localparam logic [CharWidth-1:0] ChO     = 8'h6f;
   localparam logic [CharWidth-1:0] ChA     = 8'h61;
   localparam logic [CharWidth-1:0] ChR     = 8'h72;
   localparam logic [CharWidth-1:0] ChW     = 8'h77;
   localparam logic [CharWidth-1:0] ChX     = 8'h78;

   state_type            s;
   state_type            applied;
   logic                 is_digit;
   logic                 who_ok;
   logic [2:0]           who_val;
   logic                 op_ok;
   op_type               op_val;
   logic                 perm_ok;
   logic [2:0]           perm_val;
   logic [2:0]           who_eff;
   logic [ModeWidth-1:0] clause_mode;

   // state after the first-beat load
   always_comb begin
      s = state_cur;
      if (first) begin
         s = StateReset;
         s.orig_mode = start_mode;
         s.work_mode = start_mode;
      end
   end

   always_comb begin
      is_digit = (symbol inside {[ChZero:ChSeven]});
      who_ok   = 1'b1;
      who_val  = 3'd0;
      case (symbol)
         ChU:     who_val = 3'b100;
         ChG:     who_val = 3'b010;
         ChO:     who_val = 3'b001;
         ChA:     who_val = 3'b111;
         default: who_ok  = 1'b0;
      endcase
      op_ok  = 1'b1;
      op_val = OP_ADD;
      case (symbol)
         ChPlus:  op_val = OP_ADD;
         ChMinus: op_val = OP_SUB;
         ChEq:    op_val = OP_SET;
         default: op_ok  = 1'b0;
      endcase
      perm_ok  = 1'b1;
      perm_val = 3'd0;
      case (symbol)
         ChR:     perm_val = 3'd4;
         ChW:     perm_val = 3'd2;
         ChX:     perm_val = 3'd1;
         ChU:     perm_val = s.orig_mode[8:6];
         ChG:     perm_val = s.orig_mode[5:3];
         ChO:     perm_val = s.orig_mode[2:0];
         default: perm_ok  = 1'b0;
      endcase
   end

   // completed clause applied to the working mode
   always_comb begin
      who_eff     = (s.who_mask != 3'd0) ? s.who_mask : 3'b100;
      clause_mode = s.work_mode;
      for (int i = 0; i < 3; i++) begin
         if (who_eff[i]) begin
            case (s.op_kind)
               OP_SUB:  clause_mode[i*3 +: 3] = clause_mode[i*3 +: 3] & ~s.perm_bits;
               OP_SET:  clause_mode[i*3 +: 3] = s.perm_bits;
               default: clause_mode[i*3 +: 3] = clause_mode[i*3 +: 3] | s.perm_bits;
            endcase
         end
      end
      applied           = s;
      applied.octal_acc = '0;
      applied.who_mask  = '0;
      applied.op_kind   = OP_ADD;
      applied.perm_bits = '0;
      applied.phase     = PH_START;
      case (s.phase)
         PH_OCT:  applied.work_mode = s.work_mode | s.octal_acc;
         PH_PERM: applied.work_mode = clause_mode;
         default: applied.work_mode = s.work_mode;
      endcase
   end

   always_comb begin
      state_nxt    = s;
      result.emit  = 1'b0;
      result.mode  = '0;
      result.error = 1'b0;
      if (symbol == ChNul) begin
         result.emit = 1'b1;
         if (s.error_seen || s.phase == PH_WHO) begin
            result.error = 1'b1;
         end else begin
            result.mode = applied.work_mode;
         end
         state_nxt           = StateReset;
         state_nxt.orig_mode = s.orig_mode;
         state_nxt.work_mode = s.orig_mode;
      end else if (!s.error_seen) begin
         case (s.phase)
            PH_START: begin
               if (is_digit) begin
                  state_nxt.octal_acc = {{(ModeWidth-3){1'b0}}, symbol[2:0]};
                  state_nxt.phase     = PH_OCT;
               end else if (who_ok) begin
                  state_nxt.who_mask = who_val;
                  state_nxt.phase    = PH_WHO;
               end else if (op_ok) begin
                  state_nxt.op_kind   = op_val;
                  state_nxt.perm_bits = '0;
                  state_nxt.phase     = PH_PERM;
               end else begin
                  state_nxt.error_seen = 1'b1;
               end
            end
            PH_OCT: begin
               if (is_digit) begin
                  state_nxt.octal_acc = {s.octal_acc[ModeWidth-4:0], symbol[2:0]};
               end else if (symbol == ChComma) begin
                  state_nxt = applied;
               end else begin
                  state_nxt.error_seen = 1'b1;
               end
            end
            PH_WHO: begin
               if (who_ok) begin
                  state_nxt.who_mask = s.who_mask | who_val;
               end else if (op_ok) begin
                  state_nxt.op_kind   = op_val;
                  state_nxt.perm_bits = '0;
                  state_nxt.phase     = PH_PERM;
               end else begin
                  state_nxt.error_seen = 1'b1;
               end
            end
            PH_PERM: begin
               if (perm_ok) begin
                  state_nxt.perm_bits = s.perm_bits | perm_val;
               end else if (symbol == ChComma) begin
                  state_nxt = applied;
               end else begin
                  state_nxt.error_seen = 1'b1;
               end
            end
            default: begin
               state_nxt.error_seen = 1'b1;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

/* src/symbolic_mode_parser.sv */
// Symbolic mode parser: one character beat per cycle, result on the NUL beat.
// A request beat passes the input register, then the result register, before
// its response is valid. Throughput: one beat per cycle, held only while a
// response beat is stalled. Reset clears parse state, modes and both valids.
// Top level; depends on smp_pkg and smp_step.
`default_nettype none
module symbolic_mode_parser (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire [smp_pkg::CharWidth-1:0] req_symbol,
   input  wire                          req_first,
   input  wire [smp_pkg::ModeWidth-1:0] req_start_mode,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [smp_pkg::ModeWidth-1:0] rsp_mode_out,
   output logic                         rsp_parse_error
);
   import smp_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [CharWidth-1:0] in_symbol_ff;
   logic                 in_first_ff;
   logic [ModeWidth-1:0] in_start_ff;
   state_type            state_ff, state_in;
   logic                 out_valid_ff, out_valid_in;
   logic [ModeWidth-1:0] out_mode_ff;
   logic                 out_error_ff;
   result_type           step_result;
   logic                 advance;

   smp_step u_step (
      .state_cur  (state_ff),
      .symbol     (in_symbol_ff),
      .first      (in_first_ff),
      .start_mode (in_start_ff),
      .state_nxt  (state_in),
      .result     (step_result)
   );

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      out_valid_in = advance ? (in_valid_ff && step_result.emit) : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= StateReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (in_valid_ff && advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_symbol_ff <= req_symbol;
         in_first_ff  <= req_first;
         in_start_ff  <= req_start_mode;
      end
      if (in_valid_ff && advance && step_result.emit) begin
         out_mode_ff  <= step_result.mode;
         out_error_ff <= step_result.error;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_mode_out    = out_mode_ff;
   assign rsp_parse_error = out_error_ff;

endmodule
`default_nettype wire

/* test/smp_checker.sv */
// Scoreboard for the symbolic mode parser: follows every request beat with its
// own parser state, queues the expected mode for each string and compares the
// response beats in order. Depends on smp_pkg.
`timescale 1ns / 100ps
module smp_checker (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   input  wire                          req_stall,
   input  wire [smp_pkg::CharWidth-1:0] req_symbol,
   input  wire                          req_first,
   input  wire [smp_pkg::ModeWidth-1:0] req_start_mode,
   input  wire                          rsp_valid,
   input  wire                          rsp_stall,
   input  wire [smp_pkg::ModeWidth-1:0] rsp_mode_out,
   input  wire                          rsp_parse_error,
   output int                           fail_count,
   output int                           outstanding
);
   import smp_pkg::*;

   localparam logic [7:0] ChNul    = 8'h00;
   localparam logic [7:0] ChComma  = ",";
   localparam logic [7:0] ChPlus   = "+";
   localparam logic [7:0] ChMinus  = "-";
   localparam logic [7:0] ChEquals = "=";
   localparam logic [7:0] ChZero   = "0";
   localparam logic [7:0] ChSeven  = "7";
   localparam logic [7:0] ChU      = "u";
   localparam logic [7:0] ChG      = "g";
   localparam logic [7:0] ChO      = "o";
   localparam logic [7:0] ChA      = "a";
   localparam logic [7:0] ChR      = "r";
   localparam logic [7:0] ChW      = "w";
   localparam logic [7:0] ChX      = "x";

   typedef struct packed {
      logic [ModeWidth-1:0] mode;
      logic                 malformed;
   } mode_result_type;

   mode_result_type expected_modes[$];

   logic [ModeWidth-1:0] work;
   logic [ModeWidth-1:0] orig;
   logic [ModeWidth-1:0] acc;
   logic [2:0]           who;
   op_type               op;
   logic [2:0]           perm;
   phase_type            ph;
   logic                 err;
   int                   failures = 0;

   // {hit, mask}
   function automatic logic [3:0] who_of(input logic [7:0] c);
      case (c)
         ChU: return 4'b1100;
         ChG: return 4'b1010;
         ChO: return 4'b1001;
         ChA: return 4'b1111;
         default: return 4'b0000;
      endcase
   endfunction

   // {hit, operator}
   function automatic logic [2:0] op_of(input logic [7:0] c);
      case (c)
         ChPlus:   return {1'b1, OP_ADD};
         ChMinus:  return {1'b1, OP_SUB};
         ChEquals: return {1'b1, OP_SET};
         default:  return 3'b000;
      endcase
   endfunction

   // {hit, bits}; copy letters read the starting mode
   function automatic logic [3:0] perm_of(input logic [7:0] c);
      case (c)
         ChR: return 4'b1100;
         ChW: return 4'b1010;
         ChX: return 4'b1001;
         ChU: return {1'b1, orig[8:6]};
         ChG: return {1'b1, orig[5:3]};
         ChO: return {1'b1, orig[2:0]};
         default: return 4'b0000;
      endcase
   endfunction

   function automatic void clear_parse();
      acc  = '0;
      who  = '0;
      op   = OP_ADD;
      perm = '0;
      ph   = PH_START;
      err  = 1'b0;
   endfunction

   function automatic void close_clause();
      logic [2:0]           whom;
      logic [ModeWidth-1:0] field;
      logic [ModeWidth-1:0] bits;
      whom = (who != 3'b000) ? who : 3'b100;
      if (ph == PH_OCT) begin
         work = work | acc;
      end else if (ph == PH_PERM) begin
         for (int i = 0; i < 3; i++) begin
            if (whom[i]) begin
               field = ModeWidth'(7) << (3 * i);
               bits  = ModeWidth'(perm) << (3 * i);
               if (op == OP_SUB) begin
                  work = work & ~bits;
               end else begin
                  if (op == OP_SET) work = work & ~field;
                  work = work | bits;
               end
            end
         end
      end
      acc  = '0;
      who  = '0;
      op   = OP_ADD;
      perm = '0;
      ph   = PH_START;
   endfunction

   function automatic void parse_symbol(input logic [7:0] c, input logic frst,
                                        input logic [ModeWidth-1:0] start);
      logic [3:0]      w;
      logic [2:0]      o;
      logic [3:0]      p;
      logic            digit;
      mode_result_type r;
      if (frst) begin
         orig = start;
         work = start;
         clear_parse();
      end
      if (c == ChNul) begin
         if (!err) begin
            if (ph == PH_WHO) err = 1'b1;
            else close_clause();
         end
         r.mode      = err ? '0 : work;
         r.malformed = err;
         expected_modes.push_back(r);
         clear_parse();
         work = orig;
         return;
      end
      if (err) return;
      w     = who_of(c);
      o     = op_of(c);
      p     = perm_of(c);
      digit = (c >= ChZero) && (c <= ChSeven);
      case (ph)
         PH_START: begin
            if (digit) begin
               acc = ModeWidth'(c[2:0]);
               ph  = PH_OCT;
            end else if (w[3]) begin
               who = w[2:0];
               ph  = PH_WHO;
            end else if (o[2]) begin
               op   = op_type'(o[1:0]);
               perm = '0;
               ph   = PH_PERM;
            end else begin
               err = 1'b1;
            end
         end
         PH_OCT: begin
            if (digit) acc = {acc[ModeWidth-4:0], c[2:0]};
            else if (c == ChComma) close_clause();
            else err = 1'b1;
         end
         PH_WHO: begin
            if (w[3]) begin
               who = who | w[2:0];
            end else if (o[2]) begin
               op   = op_type'(o[1:0]);
               perm = '0;
               ph   = PH_PERM;
            end else begin
               err = 1'b1;
            end
         end
         default: begin
            if (p[3]) perm = perm | p[2:0];
            else if (c == ChComma) close_clause();
            else err = 1'b1;
         end
      endcase
   endfunction

   always @(posedge clock) begin : watch
      mode_result_type want;
      if (reset) begin
         work = '0;
         orig = '0;
         clear_parse();
         expected_modes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_modes.size() == 0) begin
               if (failures < 10)
                  $display("%0t: unexpected beat, mode %h parse_error %b",
                           $time, rsp_mode_out, rsp_parse_error);
               failures = failures + 1;
            end else begin
               want = expected_modes.pop_front();
               if (rsp_mode_out !== want.mode || rsp_parse_error !== want.malformed) begin
                  if (failures < 10)
                     $display("%0t: mismatch, mode %h expected %h, parse_error %b expected %b",
                              $time, rsp_mode_out, want.mode, rsp_parse_error,
                              want.malformed);
                  failures = failures + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            parse_symbol(req_symbol, req_first, req_start_mode);
      end
      fail_count  <= failures;
      outstanding <= expected_modes.size();
   end

endmodule

/* test/tb.sv */
// Top of the symbolic mode parser testbench: clock, reset, string stimulus with
// random gaps and response stalls, verdict. Depends on smp_pkg, the parser
// and smp_checker.
`timescale 1ns / 100ps
module tb;
   import smp_pkg::*;

   localparam int         CycleLimit  = 800000;
   localparam int         TargetBeats = 1226;
   localparam logic [7:0] EndOfString = 8'h00;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic [CharWidth-1:0] req_symbol     = '0;
   logic                 req_first      = 1'b0;
   logic [ModeWidth-1:0] req_start_mode = '0;
   logic                 rsp_stall      = 1'b0;
   wire                  req_stall;
   wire                  rsp_valid;
   wire [ModeWidth-1:0]  rsp_mode_out;
   wire                  rsp_parse_error;
   int                   fail_count;
   int                   outstanding;
   int                   cycles     = 0;
   int                   beats      = 0;
   int                   stall_hold = 0;
   logic                 calm       = 1'b0;

   always #1 clock = ~clock;

   symbolic_mode_parser i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_symbol      (req_symbol),
      .req_first       (req_first),
      .req_start_mode  (req_start_mode),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_mode_out    (rsp_mode_out),
      .rsp_parse_error (rsp_parse_error)
   );

   smp_checker i_chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_symbol      (req_symbol),
      .req_first       (req_first),
      .req_start_mode  (req_start_mode),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_mode_out    (rsp_mode_out),
      .rsp_parse_error (rsp_parse_error),
      .fail_count      (fail_count),
      .outstanding     (outstanding)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // stall bursts on the response side, mostly short
   always @(posedge clock) begin : stall_gen
      int r;
      r = $urandom_range(0, 99);
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else if (calm) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 4;
      end else if (r < 50) begin
         rsp_stall  <= 1'b0;
         stall_hold <= $urandom_range(0, 7);
      end else if (r < 85) begin
         rsp_stall  <= 1'b1;
         stall_hold <= $urandom_range(0, 2);
      end else if (r < 97) begin
         rsp_stall  <= 1'b1;
         stall_hold <= $urandom_range(3, 11);
      end else begin
         rsp_stall  <= 1'b1;
         stall_hold <= $urandom_range(30, 80);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic string with_char(input string s, input logic [7:0] c);
      string t;
      t = {s, " "};
      t.putc(t.len() - 1, c);
      return t;
   endfunction

   function automatic logic [7:0] pick(input string set);
      return set.getc($urandom_range(0, set.len() - 1));
   endfunction

   function automatic string mode_clause();
      string s;
      int    n;
      s = "";
      if ($urandom_range(0, 3) == 0) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 4);
         for (int k = 0; k < n; k++) s = with_char(s, pick("01234567"));
         return s;
      end
      n = $urandom_range(0, 3);
      for (int k = 0; k < n; k++) s = with_char(s, pick("ugoa"));
      if ($urandom_range(0, 19) != 0) s = with_char(s, pick("+-="));
      n = $urandom_range(0, 4);
      for (int k = 0; k < n; k++) s = with_char(s, pick("rwxugo"));
      return s;
   endfunction

   function automatic string mode_string();
      string s;
      int    r;
      int    n;
      int    pos;
      s = "";
      r = $urandom_range(0, 99);
      if (r < 4) return s;
      if (r < 9) begin
         n = $urandom_range(1, 6);
         for (int k = 0; k < n; k++) s = with_char(s, 8'($urandom_range(1, 255)));
         return s;
      end
      n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++) begin
         if (k > 0) s = {s, ","};
         s = {s, mode_clause()};
      end
      if ($urandom_range(0, 9) == 0) s = {s, ","};
      if (s.len() > 0 && $urandom_range(0, 4) == 0) begin
         pos = $urandom_range(0, s.len() - 1);
         if ($urandom_range(0, 1) == 0)
            s.putc(pos, 8'($urandom_range(1, 255)));
         else
            s.putc(pos, pick("ugoarwx+-=,0123456789"));
      end
      return s;
   endfunction

   task automatic send_beat(input logic [7:0] sym, input logic frst,
                            input logic [ModeWidth-1:0] start);
      int gap;
      req_valid      <= 1'b1;
      req_symbol     <= sym;
      req_first      <= frst;
      req_start_mode <= start;
      do @(posedge clock); while (req_stall);
      beats = beats + 1;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // terminating beat is appended; stray first beats only when asked
   task automatic send_string(input string s, input logic frst,
                              input logic [ModeWidth-1:0] start, input logic stray);
      logic [7:0]           sym;
      logic                 f;
      logic [ModeWidth-1:0] m;
      for (int i = 0; i <= s.len(); i++) begin
         sym = (i < s.len()) ? s.getc(i) : EndOfString;
         f   = (i == 0) ? frst : (stray && $urandom_range(0, 49) == 0);
         m   = (i == 0) ? start : ModeWidth'($urandom);
         send_beat(sym, f, m);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int strings;
      strings = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_string("u-w", 1'b1, 16'hFFFF, 1'b0);
      send_string("", 1'b1, 16'h0000, 1'b0);
      send_string("go=u,a+x,", 1'b1, 16'o644, 1'b0);
      // no first: reloads the previous start mode, digits overflow 16 bits
      send_string("777777", 1'b0, 16'h5A5A, 1'b0);
      send_beat(8'hFF, 1'b1, 16'h8001);
      send_beat(EndOfString, 1'b0, 16'h7FFE);
      send_string("u", 1'b0, 16'h0000, 1'b0);
      wait_idle();

      while (beats < TargetBeats) begin
         calm <= ($urandom_range(0, 9) == 0);
         send_string(mode_string(), ($urandom_range(0, 99) < 85),
                     ModeWidth'($urandom), 1'b1);
         strings = strings + 1;
         if (strings % 40 == 0) wait_idle();
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* filelist.f */
src/smp_pkg.sv
src/smp_step.sv
src/symbolic_mode_parser.sv
test/smp_checker.sv
test/tb.sv
